// ----- src/arq_send_window_core_assert.svh -----
// Assertion macros shared by the verification files of the send window core.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ARQ_SEND_WINDOW_CORE_ASSERT_SVH
`define ARQ_SEND_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ARQSW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ARQSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/arqsw_pkg.sv -----
// Package for the ARQ send window core: sequencer states, sequence space and code constants.
// Depends on nothing; used by the core and its checker.
`default_nettype none

package arqsw_pkg;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DISP,
      S_REC_RD, S_REC_EV, S_ADV_INIT, S_ADV_RD, S_ADV_EV, S_ADV_END,
      S_FN_RD, S_FN_EV, S_INS_RD, S_INS_EV,
      S_SET,
      S_AQ_RD, S_AQ_EV,
      S_WM, S_KIND, S_PK_EV, S_RT0, S_RT1_RD, S_RT1_EV,
      S_RS_RD, S_RS_EV, S_RS_END, S_RS_CHK,
      S_TG_RD, S_TG_EV, S_OUT
   } seq_state_type;

   // The sequence numbers on the ports are 7 bits wide, so the space is fixed.
   localparam int SEQ_SPACE = 128;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_SET    = 2'd1;
   localparam logic [1:0] MODE_NEXT   = 2'd2;
   localparam logic [1:0] MODE_ACKQ   = 2'd3;

   localparam logic [1:0] SLOT_INVALID = 2'd0;
   localparam logic [1:0] SLOT_NACK    = 2'd1;
   localparam logic [1:0] SLOT_PENDING = 2'd2;
   localparam logic [1:0] SLOT_ACKED   = 2'd3;

   localparam logic [2:0] STAT_OK      = 3'd0;
   localparam logic [2:0] STAT_FULL    = 3'd1;
   localparam logic [2:0] STAT_NOT_SEQ = 3'd2;
   localparam logic [2:0] STAT_BUSY    = 3'd3;
   localparam logic [2:0] STAT_RANGE   = 3'd4;

   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_NACK_THR = 1'b1;

   localparam logic [6:0] WINDOW_RESET = 7'd64;
   localparam logic [6:0] NACK_THR_RESET = 7'd10;

endpackage

`default_nettype wire

// ----- src/arq_send_window_core.sv -----
// Sender side of a selective-repeat ARQ window; a sequencer walks a slot state memory,
// reading and then evaluating one slot at a time. Uses arqsw_pkg. One word at a time;
// the next can be taken in the cycle after the result leaves. Reset starts a clearing
// pass over all 128 slots.
`default_nettype none

module arq_send_window_core #(
   parameter int RECYCLE_SPAN = 20,
   parameter int TAG_BITS     = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_mode,
   input  wire logic [6:0]          req_seq_number,
   input  wire logic [TAG_BITS-1:0] req_block_tag,
   input  wire logic [1:0]          req_new_state,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_status,
   output logic                     rsp_block_valid,
   output logic [TAG_BITS-1:0]      rsp_block_tag_out,
   output logic [6:0]               rsp_block_seq,
   output logic                     rsp_ack_request,
   output logic [6:0]               rsp_send_state_out,
   output logic [6:0]               rsp_ack_state_out,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import arqsw_pkg::*;

   localparam int PW   = $clog2(SEQ_SPACE);
   localparam int SW   = PW + 8;
   localparam int CMAX = (RECYCLE_SPAN > 127) ? RECYCLE_SPAN : 127;
   localparam int CW   = $clog2(CMAX + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(SEQ_SPACE - 1);

   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] x);
      return (x == LAST_SLOT) ? '0 : x + 1'b1;
   endfunction

   logic [1:0]          slot_state_ff [SEQ_SPACE];
   logic [TAG_BITS-1:0] slot_tag_ff [SEQ_SPACE];

   seq_state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, send_ff, send_in;
   logic [PW-1:0] ack_ff, ack_in, retx_ff, retx_in, idx_ff, idx_in;
   logic [PW-1:0] seq_out_ff, seq_out_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [6:0]    nk_ff, nk_in, pd_ff, pd_in;
   logic [SW-1:0] vaws_ff, vaws_in, wend_ff, wend_in;
   logic          met_ff, met_in;
   logic [6:0]    win_ff, thr_ff;
   logic [1:0]    mode_ff, mode_in, nst_ff, nst_in;
   logic [6:0]    seqin_ff, seqin_in;
   logic [TAG_BITS-1:0] tagin_ff, tagin_in, tag_out_ff, tag_out_in, tag_rd_ff;
   logic [2:0]    status_ff, status_in;
   logic          bvalid_ff, bvalid_in, ackreq_ff, ackreq_in;
   logic [1:0]    st_rd_ff;

   logic          st_we, tag_we;
   logic [PW-1:0] st_waddr, rd_addr;
   logic [1:0]    st_wdata;
   logic          accept, cfg_wr, seq_oor, outst, in_span, kind1, kind2;
   logic [PW-1:0] seq_idx, nx_retx;

   assign accept  = req_valid && !req_stall;
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign seq_oor = 32'(seqin_ff) >= SEQ_SPACE;
   assign seq_idx = PW'(seqin_ff);
   assign outst   = (st_rd_ff == SLOT_NACK) || (st_rd_ff == SLOT_PENDING);
   assign nx_retx = (nxt(retx_ff) == nxt(send_ff)) ? ack_ff : nxt(retx_ff);

   // The retransmit pointer counts as in range between tail and send state, wrapping.
   always_comb begin
      if (send_ff > tail_ff) begin
         in_span = (retx_ff >= tail_ff) && (retx_ff < send_ff);
      end else if (send_ff == tail_ff) begin
         in_span = (retx_ff == tail_ff);
      end else begin
         in_span = (retx_ff < send_ff) || (retx_ff >= tail_ff);
      end
   end

   assign kind1 = ((vaws_ff > SW'(send_ff)) && (send_ff >= ack_ff)) ||
                  ((ack_ff >= send_ff) && (wend_ff > SW'(send_ff)));
   assign kind2 = ((vaws_ff == SW'(send_ff)) && (send_ff > ack_ff)) ||
                  ((ack_ff > send_ff) && (wend_ff == SW'(send_ff)));

   always_comb begin
      case (state_ff)
         S_INS_RD:          rd_addr = head_ff;
         S_KIND:            rd_addr = send_ff;
         S_RT1_RD, S_RS_END: rd_addr = retx_ff;
         default:           rd_addr = idx_ff;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR:      if (idx_ff == LAST_SLOT) state_in = S_IDLE;
         S_IDLE:     if (accept) state_in = S_DISP;
         S_DISP: begin
            case (mode_ff)
               MODE_INSERT: state_in = S_REC_RD;
               MODE_SET:    state_in = S_SET;
               MODE_NEXT:   state_in = S_WM;
               default:     state_in = S_AQ_RD;
            endcase
         end
         S_REC_RD:   state_in = (cnt_ff == CW'(RECYCLE_SPAN)) ? S_ADV_INIT : S_REC_EV;
         S_REC_EV:   state_in = outst ? S_ADV_INIT : S_REC_RD;
         S_ADV_INIT: state_in = (tail_ff != head_ff) ? S_ADV_RD : S_ADV_END;
         S_ADV_RD:   state_in = S_ADV_EV;
         S_ADV_EV:   state_in = (outst || idx_ff == head_ff) ? S_ADV_END : S_ADV_RD;
         S_ADV_END:  state_in = met_ff ? S_FN_RD : S_INS_RD;
         S_FN_RD:    state_in = (cnt_ff == CW'(win_ff)) ? S_INS_RD : S_FN_EV;
         S_FN_EV:    state_in = (st_rd_ff == SLOT_NACK) ? S_INS_RD : S_FN_RD;
         S_INS_RD:   state_in = S_INS_EV;
         S_INS_EV:   state_in = S_OUT;
         S_SET:      state_in = S_OUT;
         S_AQ_RD:    state_in = (cnt_ff == CW'(win_ff)) ? S_OUT : S_AQ_EV;
         S_AQ_EV:    state_in = S_AQ_RD;
         S_WM:       if (wend_ff < SW'(SEQ_SPACE)) state_in = S_KIND;
         S_KIND:     state_in = kind1 ? S_PK_EV : (kind2 ? S_RT0 : S_OUT);
         S_PK_EV:    state_in = (st_rd_ff == SLOT_NACK) ? S_TG_RD : S_RT0;
         S_RT0:      state_in = S_RT1_RD;
         S_RT1_RD:   state_in = S_RT1_EV;
         S_RT1_EV:   state_in = outst ? S_TG_RD : S_RS_RD;
         S_RS_RD: begin
            if (cnt_ff == CW'(win_ff) || idx_ff == nxt(send_ff)) state_in = S_RS_END;
            else state_in = S_RS_EV;
         end
         S_RS_EV:    state_in = (st_rd_ff == SLOT_PENDING) ? S_RS_END : S_RS_RD;
         S_RS_END:   state_in = S_RS_CHK;
         S_RS_CHK:   state_in = (st_rd_ff == SLOT_PENDING) ? S_TG_RD : S_OUT;
         S_TG_RD:    state_in = S_TG_EV;
         S_TG_EV:    state_in = S_OUT;
         S_OUT:      if (!rsp_stall) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      head_in = head_ff;   tail_in = tail_ff;   send_in = send_ff;
      ack_in = ack_ff;     retx_in = retx_ff;   idx_in = idx_ff;
      seq_out_in = seq_out_ff;  cnt_in = cnt_ff;  nk_in = nk_ff;  pd_in = pd_ff;
      vaws_in = vaws_ff;   wend_in = wend_ff;   met_in = met_ff;
      mode_in = mode_ff;   nst_in = nst_ff;     seqin_in = seqin_ff;  tagin_in = tagin_ff;
      tag_out_in = tag_out_ff;  status_in = status_ff;
      bvalid_in = bvalid_ff;    ackreq_in = ackreq_ff;
      st_we = 1'b0;  st_waddr = idx_ff;  st_wdata = SLOT_INVALID;  tag_we = 1'b0;
      case (state_ff)
         S_CLR: begin
            st_we = 1'b1;
            idx_in = nxt(idx_ff);
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;  seqin_in = req_seq_number;
               tagin_in = req_block_tag;  nst_in = req_new_state;
               status_in = STAT_OK;  bvalid_in = 1'b0;  ackreq_in = 1'b0;
               tag_out_in = '0;  seq_out_in = '0;
            end
         end
         S_DISP: begin
            cnt_in = '0;  nk_in = '0;  pd_in = '0;
            idx_in = (mode_ff == MODE_ACKQ) ? ack_ff : head_ff;
            vaws_in = SW'(ack_ff) + SW'(win_ff);
            wend_in = SW'(ack_ff) + SW'(win_ff);
         end
         S_REC_EV: begin
            if (!outst) begin
               st_we = 1'b1;
               idx_in = nxt(idx_ff);
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ADV_INIT: begin
            met_in = 1'b0;
            idx_in = tail_ff;
         end
         S_ADV_EV: begin
            tail_in = idx_ff;
            if (idx_ff == send_ff) met_in = 1'b1;
            idx_in = nxt(idx_ff);
         end
         S_ADV_END: begin
            ack_in = tail_ff;
            idx_in = tail_ff;
            cnt_in = '0;
         end
         S_FN_RD: begin
            if (cnt_ff == CW'(win_ff)) send_in = ack_ff;
         end
         S_FN_EV: begin
            if (st_rd_ff == SLOT_NACK) send_in = idx_ff;
            idx_in = nxt(idx_ff);
            cnt_in = cnt_ff + 1'b1;
         end
         S_INS_EV: begin
            if (seq_oor) status_in = STAT_RANGE;
            else if (nxt(head_ff) == tail_ff) status_in = STAT_FULL;
            else if (seq_idx != head_ff) status_in = STAT_NOT_SEQ;
            else if (st_rd_ff != SLOT_INVALID) status_in = STAT_BUSY;
            else begin
               st_we = 1'b1;  st_waddr = head_ff;  st_wdata = SLOT_NACK;
               tag_we = 1'b1;
               head_in = nxt(head_ff);
            end
         end
         S_SET: begin
            if (seq_oor) status_in = STAT_RANGE;
            else begin
               st_we = 1'b1;  st_waddr = seq_idx;  st_wdata = nst_ff;
            end
         end
         S_AQ_RD: begin
            if (cnt_ff == CW'(win_ff)) ackreq_in = (nk_ff < thr_ff) && (pd_ff != '0);
         end
         S_AQ_EV: begin
            if (st_rd_ff == SLOT_NACK) nk_in = nk_ff + 1'b1;
            if (st_rd_ff == SLOT_PENDING) pd_in = pd_ff + 1'b1;
            idx_in = nxt(idx_ff);
            cnt_in = cnt_ff + 1'b1;
         end
         S_WM: begin
            if (wend_ff >= SW'(SEQ_SPACE)) wend_in = wend_ff - SW'(SEQ_SPACE);
         end
         S_PK_EV: begin
            if (st_rd_ff == SLOT_NACK) begin
               st_we = 1'b1;  st_waddr = send_ff;  st_wdata = SLOT_PENDING;
               seq_out_in = send_ff;
               send_in = nxt(send_ff);
            end
         end
         S_RT0: begin
            if (!in_span) retx_in = ack_ff;
         end
         S_RT1_EV: begin
            if (outst) begin
               st_we = 1'b1;  st_waddr = retx_ff;  st_wdata = SLOT_PENDING;
               seq_out_in = retx_ff;
               retx_in = nx_retx;
            end else begin
               idx_in = retx_ff;
               cnt_in = '0;
            end
         end
         S_RS_RD: begin
            if (cnt_ff != CW'(win_ff) && idx_ff == nxt(send_ff)) retx_in = ack_ff;
         end
         S_RS_EV: begin
            if (st_rd_ff == SLOT_PENDING) retx_in = idx_ff;
            idx_in = nxt(idx_ff);
            cnt_in = cnt_ff + 1'b1;
         end
         S_RS_CHK: begin
            if (st_rd_ff == SLOT_PENDING) begin
               st_we = 1'b1;  st_waddr = retx_ff;  st_wdata = SLOT_PENDING;
               seq_out_in = retx_ff;
               retx_in = nx_retx;
            end else begin
               // Nothing to send: the window freezes at the send state.
               ack_in = send_ff;
               retx_in = send_ff;
            end
         end
         S_TG_EV: begin
            bvalid_in = 1'b1;
            tag_out_in = tag_rd_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) slot_state_ff[st_waddr] <= st_wdata;
      st_rd_ff <= slot_state_ff[rd_addr];
      if (tag_we) slot_tag_ff[head_ff] <= tagin_ff;
      tag_rd_ff <= slot_tag_ff[seq_out_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         head_ff <= '0;  tail_ff <= '0;  send_ff <= '0;  ack_ff <= '0;  retx_ff <= '0;
         idx_ff <= '0;
         win_ff <= WINDOW_RESET;
         thr_ff <= NACK_THR_RESET;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;  tail_ff <= tail_in;  send_ff <= send_in;
         ack_ff <= ack_in;    retx_ff <= retx_in;  idx_ff <= idx_in;
         if (cfg_wr && csr_paddr[2] == REG_WINDOW) win_ff <= csr_pwdata[6:0];
         if (cfg_wr && csr_paddr[2] == REG_NACK_THR) thr_ff <= csr_pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      seq_out_ff <= seq_out_in;  cnt_ff <= cnt_in;  nk_ff <= nk_in;  pd_ff <= pd_in;
      vaws_ff <= vaws_in;  wend_ff <= wend_in;  met_ff <= met_in;
      mode_ff <= mode_in;  nst_ff <= nst_in;  seqin_ff <= seqin_in;  tagin_ff <= tagin_in;
      tag_out_ff <= tag_out_in;  status_ff <= status_in;
      bvalid_ff <= bvalid_in;  ackreq_ff <= ackreq_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_status         = status_ff;
   assign rsp_block_valid    = bvalid_ff;
   assign rsp_block_tag_out  = tag_out_ff;
   assign rsp_block_seq      = 7'(seq_out_ff);
   assign rsp_ack_request    = ackreq_ff;
   assign rsp_send_state_out = 7'(send_ff);
   assign rsp_ack_state_out  = 7'(ack_ff);
   assign csr_pready         = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_WINDOW) ? {25'd0, win_ff} : {25'd0, thr_ff};

endmodule

`default_nettype wire

// ----- src/arqsw_checker.sv -----
// Port-level checker for the ARQ send window core, bound to the top level.
// Depends on arqsw_pkg and the macros in arq_send_window_core_assert.svh.
`default_nettype none
`include "arq_send_window_core_assert.svh"

module arqsw_checker #(
   parameter int TAG_BITS = 16
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [2:0]          rsp_status,
   input wire logic                rsp_block_valid,
   input wire logic [TAG_BITS-1:0] rsp_block_tag_out,
   input wire logic [6:0]          rsp_block_seq,
   input wire logic                rsp_ack_request
);
   import arqsw_pkg::*;

   `ARQSW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_block_seq),
      "stalled result word changed")
   `ARQSW_ASSERT_NOW(a_busy_with_rsp, rsp_valid, req_stall,
      "request taken while a result word is pending")
   `ARQSW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "second request word taken while one is in work")
   `ARQSW_ASSERT_NOW(a_idle_block_zero, rsp_valid && !rsp_block_valid,
      rsp_block_seq == 7'd0 && rsp_block_tag_out == '0,
      "block fields not zero without a chosen block")
   `ARQSW_ASSERT_NOW(a_error_clean, rsp_valid && rsp_status != STAT_OK,
      !rsp_block_valid && !rsp_ack_request,
      "error status carries a block or ack request")

endmodule

bind arq_send_window_core arqsw_checker #(.TAG_BITS(TAG_BITS)) u_arqsw_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_block_valid(rsp_block_valid),
   .rsp_block_tag_out(rsp_block_tag_out), .rsp_block_seq(rsp_block_seq),
   .rsp_ack_request(rsp_ack_request)
);

`default_nettype wire

// ----- dv/arq_send_window_core_test.sv -----
// Self-checking testbench for arq_send_window_core: words of random and directed
// stimulus, a built-in window predictor and a field-by-field response check.
// Depends on arqsw_pkg and the core RTL only.
`timescale 1ns / 100ps

module arq_send_window_core_test;
   import arqsw_pkg::*;

   typedef struct packed {
      logic [1:0]  mode;
      logic [6:0]  seq;
      logic [15:0] tag;
      logic [1:0]  nst;
   } word_t;

   typedef struct packed {
      logic [2:0]  status;
      logic        bvalid;
      logic [15:0] btag;
      logic [6:0]  bseq;
      logic        ackreq;
      logic [6:0]  vs;
      logic [6:0]  va;
   } verdict_t;

   localparam int NSEQ = 128;
   localparam int SPAN = 20;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_INSERT;
   logic [6:0] req_seq_number = '0;
   logic [15:0] req_block_tag = '0;
   logic [1:0] req_new_state = SLOT_INVALID;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic rsp_block_valid;
   logic [15:0] rsp_block_tag_out;
   logic [6:0] rsp_block_seq;
   logic rsp_ack_request;
   logic [6:0] rsp_send_state_out;
   logic [6:0] rsp_ack_state_out;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   arq_send_window_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_seq_number(req_seq_number), .req_block_tag(req_block_tag),
      .req_new_state(req_new_state),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_block_valid(rsp_block_valid), .rsp_block_tag_out(rsp_block_tag_out),
      .rsp_block_seq(rsp_block_seq), .rsp_ack_request(rsp_ack_request),
      .rsp_send_state_out(rsp_send_state_out), .rsp_ack_state_out(rsp_ack_state_out),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Predicted window state.
   logic [1:0] slot_st [NSEQ];
   logic [15:0] slot_tg [NSEQ];
   bit tag_written [NSEQ];
   int unsigned hd, tl, vs_p, va_p, rt_p, win_len, nack_thr;

   word_t pending_words[$];
   verdict_t expected_rsp[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned nxt(int unsigned x);
      return (x + 1) % NSEQ;
   endfunction

   function automatic bit outst(int unsigned i);
      return slot_st[i % NSEQ] == SLOT_NACK || slot_st[i % NSEQ] == SLOT_PENDING;
   endfunction

   function automatic void advance_tail();
      bit met;
      bit found;
      int unsigned i;
      int unsigned k;
      met = 0;
      found = 0;
      if (tl != hd) begin
         i = tl;
         while (1) begin
            tl = i;
            if (tl == vs_p) met = 1;
            if (outst(i) || i == hd) break;
            i = nxt(i);
         end
      end
      va_p = tl;
      if (met) begin
         for (int j = 0; j < win_len; j++) begin
            k = (tl + j) % NSEQ;
            if (slot_st[k] == SLOT_NACK) begin
               vs_p = k;
               found = 1;
               break;
            end
         end
         if (!found) vs_p = va_p;
      end
   endfunction

   function automatic bit in_sent_span(int unsigned b);
      int unsigned e;
      e = vs_p;
      if (e > tl) return b >= tl && b < e;
      if (e == tl) return b == tl;
      if (b < e) b += NSEQ;
      e += NSEQ;
      return b >= tl && b < e;
   endfunction

   function automatic int unsigned emit_retx_slot();
      int unsigned k;
      k = rt_p;
      rt_p = nxt(rt_p);
      if (rt_p == nxt(vs_p)) rt_p = va_p;
      slot_st[k] = SLOT_PENDING;
      return k;
   endfunction

   function automatic bit pick_block(output int unsigned sq);
      int unsigned va;
      int unsigned vs;
      int unsigned ws;
      int unsigned wend;
      int unsigned k;
      int kind;
      va = va_p;
      vs = vs_p;
      ws = win_len;
      wend = (va + ws) % NSEQ;
      kind = 0;
      sq = 0;
      if (va + ws > vs && vs >= va) kind = 1;
      else if (va >= vs && wend > vs) kind = 1;
      else if (va + ws == vs && vs > va) kind = 2;
      else if (va > vs && wend == vs) kind = 2;
      if (kind == 0) return 0;
      if (kind == 1 && slot_st[vs] == SLOT_NACK) begin
         vs_p = nxt(vs);
         slot_st[vs] = SLOT_PENDING;
         sq = vs;
         return 1;
      end
      if (!in_sent_span(rt_p)) rt_p = va_p;
      if (outst(rt_p)) begin
         sq = emit_retx_slot();
         return 1;
      end
      for (int j = 0; j < ws; j++) begin
         k = (rt_p + j) % NSEQ;
         if (k == nxt(vs_p)) begin
            rt_p = va_p;
            break;
         end
         if (slot_st[k] == SLOT_PENDING) begin
            rt_p = k;
            break;
         end
      end
      if (slot_st[rt_p] == SLOT_PENDING) begin
         sq = emit_retx_slot();
         return 1;
      end
      va_p = vs_p;
      rt_p = va_p;
      return 0;
   endfunction

   function automatic verdict_t predict_word(word_t w);
      verdict_t r;
      int unsigned sq;
      int unsigned nk;
      int unsigned pd;
      logic [1:0] s;
      r = '0;
      case (w.mode)
         MODE_INSERT: begin
            for (int c = 0; c < SPAN; c++) begin
               if (outst((hd + c) % NSEQ)) break;
               slot_st[(hd + c) % NSEQ] = SLOT_INVALID;
            end
            advance_tail();
            if (nxt(hd) == tl) r.status = STAT_FULL;
            else if (w.seq != hd) r.status = STAT_NOT_SEQ;
            else if (slot_st[hd] != SLOT_INVALID) r.status = STAT_BUSY;
            else begin
               slot_tg[hd] = w.tag;
               tag_written[hd] = 1;
               slot_st[hd] = SLOT_NACK;
               hd = nxt(hd);
            end
         end
         MODE_SET: slot_st[w.seq] = w.nst;
         MODE_NEXT: begin
            if (pick_block(sq)) begin
               r.bvalid = 1'b1;
               r.bseq = 7'(sq);
               r.btag = slot_tg[sq];
            end
         end
         default: begin
            nk = 0;
            pd = 0;
            for (int j = 0; j < win_len; j++) begin
               s = slot_st[(va_p + j) % NSEQ];
               if (s == SLOT_NACK) nk++;
               if (s == SLOT_PENDING) pd++;
            end
            r.ackreq = nk < nack_thr && pd > 0;
         end
      endcase
      r.vs = 7'(vs_p);
      r.va = 7'(va_p);
      return r;
   endfunction

   // A slot may only become NACK or pending once it holds a tag.
   task automatic queue_word(word_t w);
      if (w.mode == MODE_SET && !tag_written[w.seq] &&
          (w.nst == SLOT_NACK || w.nst == SLOT_PENDING))
         w.nst = w.nst == SLOT_NACK ? SLOT_INVALID : SLOT_ACKED;
      expected_rsp.push_back(predict_word(w));
      pending_words.push_back(w);
   endtask

   task automatic queue_fields(logic [1:0] m, int unsigned sq, logic [15:0] tg,
                               logic [1:0] ns);
      word_t w;
      w.mode = m;
      w.seq = 7'(sq);
      w.tag = tg;
      w.nst = ns;
      queue_word(w);
   endtask

   task automatic random_word();
      word_t w;
      int unsigned p;
      int unsigned used;
      w = word_t'($urandom);
      p = $urandom_range(99);
      used = (hd + NSEQ - tl) % NSEQ;
      if (p < 35) begin
         w.mode = MODE_INSERT;
         w.seq = 7'(hd);
      end else if (p < 60) begin
         w.mode = MODE_NEXT;
      end else if (p < 80) begin
         w.mode = MODE_SET;
         if (used > 0) w.seq = 7'((tl + $urandom_range(used - 1)) % NSEQ);
         w.nst = $urandom_range(99) < 70 ? SLOT_ACKED : SLOT_NACK;
      end else if (p < 88) begin
         w.mode = MODE_ACKQ;
      end
      queue_word(w);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [6:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {25'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_WINDOW) win_len = 32'(val);
      else nack_thr = 32'(val);
   endtask

   task automatic report_mismatch(string field, int unsigned got, int unsigned want);
      $display("%0t: %s is %0d, predicted %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   // Driver: one nonblocking update of each request signal per edge.
   always @(posedge clock) begin
      if (!reset && !(req_valid && req_stall)) begin
         if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            {req_mode, req_seq_number, req_block_tag, req_new_state} <=
               pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= $urandom_range(99) < recv_stall_pct;
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      verdict_t e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unpredicted response word", 1, 0);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
               if (rsp_block_valid !== e.bvalid)
                  report_mismatch("block_valid", rsp_block_valid, e.bvalid);
               if (rsp_block_tag_out !== e.btag)
                  report_mismatch("block_tag_out", rsp_block_tag_out, e.btag);
               if (rsp_block_seq !== e.bseq)
                  report_mismatch("block_seq", rsp_block_seq, e.bseq);
               if (rsp_ack_request !== e.ackreq)
                  report_mismatch("ack_request", rsp_ack_request, e.ackreq);
               if (rsp_send_state_out !== e.vs)
                  report_mismatch("send_state_out", rsp_send_state_out, e.vs);
               if (rsp_ack_state_out !== e.va)
                  report_mismatch("ack_state_out", rsp_ack_state_out, e.va);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      logic [6:0] wsz [8];
      logic [6:0] thr [8];
      for (int i = 0; i < NSEQ; i++) begin
         slot_st[i] = SLOT_INVALID;
         slot_tg[i] = '0;
         tag_written[i] = 0;
      end
      hd = 0; tl = 0; vs_p = 0; va_p = 0; rt_p = 0;
      win_len = 32'(WINDOW_RESET);
      nack_thr = 32'(NACK_THR_RESET);
      wsz = '{7'd64, 7'd127, 7'd1, 7'd127, 7'd2, 7'd32, 7'd100, 7'd127};
      thr = '{7'd10, 7'd127, 7'd0, 7'd1, 7'd127, 7'd5, 7'd20, 7'd3};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty window, tag extremes, out of order, every mode and state.
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_ACKQ, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_INSERT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_INSERT, 1, 16'hFFFF, SLOT_ACKED);
      queue_fields(MODE_INSERT, 127, 16'h5A5A, SLOT_NACK);
      queue_fields(MODE_INSERT, 2, 16'hA5A5, SLOT_PENDING);
      queue_fields(MODE_NEXT, 127, 16'hFFFF, SLOT_ACKED);
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_ACKQ, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_SET, 0, 16'h1234, SLOT_ACKED);
      queue_fields(MODE_SET, 1, 16'h0000, SLOT_NACK);
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      queue_fields(MODE_SET, 2, 16'h0000, SLOT_PENDING);
      queue_fields(MODE_SET, 127, 16'hFFFF, SLOT_INVALID);
      queue_fields(MODE_INSERT, 3, 16'h8001, SLOT_INVALID);
      queue_fields(MODE_SET, 1, 16'h0000, SLOT_ACKED);
      queue_fields(MODE_SET, 2, 16'h0000, SLOT_ACKED);
      queue_fields(MODE_ACKQ, 127, 16'hFFFF, SLOT_ACKED);
      queue_fields(MODE_INSERT, 3, 16'h7FFE, SLOT_INVALID);
      queue_fields(MODE_NEXT, 0, 16'h0000, SLOT_INVALID);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(REG_WINDOW, wsz[ph]);
         csr_write(REG_NACK_THR, thr[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         // Filling without acknowledgement drives the buffer to full.
         if (ph == 1) begin
            for (int i = 0; i < 130; i++)
               queue_fields(MODE_INSERT, hd, 16'($urandom), SLOT_INVALID);
         end
         for (int i = 0; i < 190; i++) begin
            random_word();
            // Sender holds off until every predicted response has come.
            if (i == 95) wait_drained();
         end
         wait_drained();
      end

      repeat (600) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// ----- arq_send_window_core.f -----
+incdir+src
src/arqsw_pkg.sv
src/arq_send_window_core.sv
src/arqsw_checker.sv
dv/arq_send_window_core_test.sv
